// ===== design/silp_pkg.sv =====
// Shared types, character codes and digit decoding for the integer literal parser.
package silp_pkg;

    // Default accumulator width
    localparam int VALUE_BITS_DEF = 32;

    // Beat widths
    localparam int CHAR_W   = 8;
    localparam int RESULT_W = 32;
    localparam int OUT_W    = ((1 + RESULT_W + 7) / 8) * 8;

    // Reset value of the allow_negative register
    localparam logic ALLOW_NEG_RST = 1'b1;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

    // Saturating count of body characters
    localparam logic [1:0] POS_MAX = 2'd3;

    typedef struct packed {
        logic       valid;
        logic [3:0] val;
    } t_digit;

    // Decode one character as a digit of base 10, or base 16 when hex is set
    function automatic t_digit digit_of(input logic [CHAR_W-1:0] c, input logic hex);
        t_digit d;
        d.valid = 1'b0;
        d.val   = 4'd0;
        if (c inside {[CH_0:CH_9]}) begin
            d.valid = 1'b1;
            d.val   = 4'(c - CH_0);
        end else if (hex && (c inside {[CH_LA:CH_LF]})) begin
            d.valid = 1'b1;
            d.val   = 4'(c - CH_LA + 8'd10);
        end else if (hex && (c inside {[CH_UA:CH_UF]})) begin
            d.valid = 1'b1;
            d.val   = 4'(c - CH_UA + 8'd10);
        end
        return d;
    endfunction

endpackage

// ===== design/strict_integer_literal_parser_core.sv =====
// Top level of the strict decimal / hex integer literal parser.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid / s_axis_tready tdata[7:0] character, tlast last_char
//  m_axis    out  m_axis_tvalid / m_axis_tready tdata[0] ok, tdata[32:1] value
//  cfg       in   i_cfg_wr_en                   i_cfg_wr_data allow_negative
//
//  Throughput is one character per cycle while no tlast beat waits; m_axis_tvalid rises
//  once the last character has passed the input register and then the result register.
//  Per character: a shift-and-add of the accumulator plus the digit, then a range check.
//  Characters without tlast never stall; a tlast beat waits in the input
//  register only while the previous result is still held on m_axis.
//  Reset is synchronous: literal state clears and allow_negative returns to 1.
module strict_integer_literal_parser_core
    import silp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    // input characters
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [CHAR_W-1:0] s_axis_tdata,   // [7:0] character
    input  logic              s_axis_tlast,   // last_char
    // results
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata    // [0] ok, [32:1] value, rest zero
);

    localparam int PW = VALUE_BITS + 4;
    localparam logic [VALUE_BITS-1:0] HALF = VALUE_BITS'(1) << (VALUE_BITS - 1);

    // Registers
    logic                  r_allow_neg;
    logic                  r_in_valid;
    logic [CHAR_W-1:0]     r_in_char;
    logic                  r_in_last;
    logic [1:0]            r_pos;
    logic                  r_neg;
    logic                  r_hex;
    logic                  r_lz;
    logic                  r_seen;
    logic                  r_bad;
    logic                  r_ovf;
    logic [VALUE_BITS-1:0] r_acc;
    logic                  r_out_valid;
    logic                  r_out_ok;
    logic [RESULT_W-1:0]   r_out_value;

    // Next values
    logic [1:0]            n_pos;
    logic                  n_neg;
    logic                  n_hex;
    logic                  n_lz;
    logic                  n_seen;
    logic                  n_bad;
    logic                  n_ovf;
    logic [VALUE_BITS-1:0] n_acc;
    logic                  n_ok;
    logic [RESULT_W-1:0]   n_value;

    logic                  adv;
    logic                  take_in;
    t_digit                dig;
    logic                  use_hex;
    logic [PW-1:0]         scaled;
    logic [PW-1:0]         prod;
    logic                  prod_ovf;
    logic                  is_sign;
    logic [VALUE_BITS-1:0] res;
    logic [VALUE_BITS+RESULT_W-1:0] res_ext;

    // Advance the held character; only a last character needs room on m_axis
    assign adv           = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    // Digit decode and the multiply-add by shifts
    assign use_hex  = r_hex && (r_pos != 2'd0);
    assign dig      = digit_of(r_in_char, use_hex);
    assign scaled   = r_hex ? {r_acc, 4'b0000}
                            : (PW'({r_acc, 3'b000}) + PW'({r_acc, 1'b0}));
    assign prod     = scaled + PW'(dig.val);
    assign prod_ovf = (prod[PW-1:VALUE_BITS] != 4'd0);
    assign is_sign  = (r_pos == 2'd0) && !r_neg && (r_in_char == CH_MINUS);

    // Step the literal state by one character
    always_comb begin
        n_pos  = r_pos;
        n_neg  = r_neg;
        n_hex  = r_hex;
        n_lz   = r_lz;
        n_seen = r_seen;
        n_bad  = r_bad;
        n_ovf  = r_ovf;
        n_acc  = r_acc;
        if (!r_bad) begin
            if (is_sign) begin
                if (r_allow_neg) n_neg = 1'b1;
                else             n_bad = 1'b1;
            end else begin
                if ((r_pos == 2'd1) && r_lz) begin
                    if ((r_in_char == CH_LX) || (r_in_char == CH_UX)) begin
                        n_hex  = 1'b1;
                        n_seen = 1'b0;
                        n_acc  = '0;
                    end else begin
                        n_bad = 1'b1;
                    end
                end else if (!dig.valid) begin
                    n_bad = 1'b1;
                end else begin
                    if (r_pos == 2'd0) n_lz = (dig.val == 4'd0);
                    n_seen = 1'b1;
                    if (!r_ovf) begin
                        if (prod_ovf) n_ovf = 1'b1;
                        else          n_acc = prod[VALUE_BITS-1:0];
                    end
                end
                if (r_pos != POS_MAX) n_pos = r_pos + 2'd1;
            end
        end
    end

    // Form the result from the state after the last character
    always_comb begin
        n_ok    = !n_bad && n_seen && !n_ovf && !(n_neg && (n_acc > HALF));
        res     = n_neg ? (VALUE_BITS'(0) - n_acc) : n_acc;
        res_ext = {{RESULT_W{1'b0}}, res};
        n_value = n_ok ? res_ext[RESULT_W-1:0] : '0;
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_neg <= ALLOW_NEG_RST;
        end else if (i_cfg_wr_en) begin
            r_allow_neg <= i_cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Literal state: advance on each character, clear after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (adv && r_in_last)) begin
            r_pos  <= 2'd0;
            r_neg  <= 1'b0;
            r_hex  <= 1'b0;
            r_lz   <= 1'b0;
            r_seen <= 1'b0;
            r_bad  <= 1'b0;
            r_ovf  <= 1'b0;
            r_acc  <= '0;
        end else if (adv) begin
            r_pos  <= n_pos;
            r_neg  <= n_neg;
            r_hex  <= n_hex;
            r_lz   <= n_lz;
            r_seen <= n_seen;
            r_bad  <= n_bad;
            r_ovf  <= n_ovf;
            r_acc  <= n_acc;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            r_out_ok    <= n_ok;
            r_out_value <= n_value;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_value, r_out_ok});

    // A rejected literal carries a zero value
    a_zero_when_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |-> (r_out_value == '0))
        else $error("result value not zero on a rejected literal");

    // Characters that end no literal never wait
    a_mid_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in_last) |-> adv)
        else $error("non-final character stalled");

    // State is clean after the last character of a literal
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_last) |=> (r_pos == 2'd0 && !r_neg && !r_bad && r_acc == '0))
        else $error("literal state not cleared after final character");

    // A malformed literal stays malformed until its end
    a_bad_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bad && !(adv && r_in_last)) |=> r_bad)
        else $error("malformed flag dropped inside a literal");

    // A new result never overwrites one that was not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !(adv && r_in_last))
        else $error("held result overwritten");

endmodule

// ===== verif/tb_strict_integer_literal_parser_core.sv =====
// Self-checking testbench for the strict decimal/hex integer literal parser core.
module tb_strict_integer_literal_parser_core
    import silp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int       HOLD_CYCLES   = 150;
    localparam int       STALL_LIMIT   = 3000;
    localparam int       PHASE_CHARS   = 140;
    localparam int       RANDOM_PHASES = 8;
    localparam int       DRAIN_CYCLES  = 4;
    localparam bit [7:0] CH_SPACE      = 8'h20;

    typedef struct packed {
        logic        ok;
        logic [31:0] value;
    } t_parsed_result;

    // Tracks the literal being parsed and the results it owes
    class literal_scoreboard;
        bit                allow_neg;
        logic [1:0]        body_pos;
        bit                neg;
        bit                hex;
        bit                lead_zero;
        bit                digit_seen;
        bit                bad;
        bit                ovf;
        longint unsigned   magnitude;
        t_parsed_result    owed[$];
        int                errors;

        function new();
            allow_neg = ALLOW_NEG_RST;
            errors    = 0;
            clear_literal();
        endfunction

        function void clear_literal();
            body_pos   = 2'd0;
            neg        = 1'b0;
            hex        = 1'b0;
            lead_zero  = 1'b0;
            digit_seen = 1'b0;
            bad        = 1'b0;
            ovf        = 1'b0;
            magnitude  = 0;
        endfunction

        // Digit weight of c in the current base, -1 if not a digit
        function int digit_value(bit [7:0] c, bit in_hex);
            if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
            if (in_hex && c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
            if (in_hex && c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
            return -1;
        endfunction

        function void accumulate(int d);
            longint unsigned radix;
            longint unsigned dv;
            radix      = hex ? 16 : 10;
            dv         = longint'(d);
            digit_seen = 1'b1;
            if (ovf) return;
            if (magnitude > (64'hFFFF_FFFF - dv) / radix) begin
                ovf = 1'b1;
                return;
            end
            magnitude = magnitude * radix + dv;
        endfunction

        function void parse_char(bit [7:0] c);
            int d;
            if (bad) return;
            // a leading sign does not count as a body character
            if (body_pos == 2'd0 && !neg && c == CH_MINUS) begin
                if (allow_neg) neg = 1'b1;
                else bad = 1'b1;
                return;
            end
            if (body_pos == 2'd0) begin
                d = digit_value(c, 1'b0);
                if (d < 0) begin
                    bad = 1'b1;
                end else begin
                    lead_zero = (d == 0);
                    accumulate(d);
                end
            end else if (body_pos == 2'd1 && lead_zero) begin
                if (c == CH_LX || c == CH_UX) begin
                    hex        = 1'b1;
                    digit_seen = 1'b0;
                    magnitude  = 0;
                end else begin
                    bad = 1'b1;
                end
            end else begin
                d = digit_value(c, hex);
                if (d < 0) bad = 1'b1;
                else accumulate(d);
            end
            if (body_pos != POS_MAX) body_pos = body_pos + 2'd1;
        endfunction

        // Note one accepted character; the last one of a literal owes a result
        function void note_char(bit [7:0] c, bit last);
            t_parsed_result  r;
            bit              good;
            longint unsigned signed_bits;
            parse_char(c);
            if (!last) return;
            good = !bad && digit_seen && !ovf;
            if (good && neg && magnitude > 64'h8000_0000) good = 1'b0;
            signed_bits = neg ? (64'd0 - magnitude) : magnitude;
            r.ok    = good;
            r.value = good ? signed_bits[31:0] : 32'd0;
            owed = {owed, r};
            clear_literal();
        endfunction

        function void check_result(logic [OUT_W-1:0] beat);
            t_parsed_result want;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result beat ok=%0b value=%h", $time,
                         beat[0], beat[32:1]);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (beat[0] !== want.ok) begin
                $display("%0t: ok expected %0b actual %0b", $time, want.ok, beat[0]);
                errors++;
            end
            if (beat[32:1] !== want.value) begin
                $display("%0t: value expected %h actual %h", $time, want.value,
                         beat[32:1]);
                errors++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_wr_en   = 1'b0;
    logic             i_cfg_wr_data = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [CHAR_W-1:0] s_axis_tdata = '0;   // [7:0] character
    logic             s_axis_tlast  = 1'b0; // last_char
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;         // [0] ok, [32:1] value, rest zero

    literal_scoreboard board = new();
    bit [7:0]          lit[$];
    bit                calm      = 1'b0;
    int                hold_req  = 0;
    int                hold_done = 0;
    int                rx_hold   = 0;
    int                idle_cycles = 0;
    int                chars_sent  = 0;

    strict_integer_literal_parser_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Check result beats and drive backpressure, with an occasional long hold-off
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req != hold_done) begin
            hold_done <= hold_req;
            rx_hold <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 10);
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Append one character to the queued literal
    function automatic void add_char(input bit [7:0] c);
        lit = {lit, c};
    endfunction

    task automatic send_beat(input bit [7:0] c, input bit last);
        if (!calm && $urandom_range(0, 99) < 5) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_char(c, last);
        chars_sent++;
    endtask

    // Send the queued literal, marking its final character
    task automatic send_literal();
        for (int i = 0; i < lit.size(); i++) send_beat(lit[i], i == lit.size() - 1);
        lit.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
        send_literal();
    endtask

    // Stop offering and wait for every owed result, then let the pipe empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_allow_negative(input bit v);
        i_cfg_wr_data <= v;
        i_cfg_wr_en   <= 1'b1;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        board.allow_neg = v;
    endtask

    function automatic bit [7:0] hex_char(int d);
        if (d < 10) return CH_0 + 8'(d);
        return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(d - 10);
    endfunction

    // Build a well-formed literal with random content into lit
    task automatic build_valid();
        int n;
        if ($urandom_range(0, 99) < 40) add_char(CH_MINUS);
        if ($urandom_range(0, 1)) begin
            n = $urandom_range(1, 11);
            if (n == 1) add_char(CH_0 + 8'($urandom_range(0, 9)));
            else add_char(CH_0 + 8'($urandom_range(1, 9)));
            for (int i = 1; i < n; i++) add_char(CH_0 + 8'($urandom_range(0, 9)));
        end else begin
            add_char(CH_0);
            add_char($urandom_range(0, 1) ? CH_UX : CH_LX);
            n = $urandom_range(1, 9);
            for (int i = 0; i < n; i++) add_char(hex_char($urandom_range(0, 15)));
        end
    endtask

    task automatic build_boundary();
        string s;
        case ($urandom_range(0, 9))
            0: s = "4294967295";
            1: s = "4294967296";
            2: s = "2147483648";
            3: s = "-2147483648";
            4: s = "-2147483649";
            5: s = "0xffffffff";
            6: s = "0X100000000";
            7: s = "-0x80000000";
            8: s = "-0x80000001";
            default: s = "0x0000000000FFFFFFFF";
        endcase
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
    endtask

    // Corrupt a well-formed literal, or build a bare or noisy one
    task automatic build_broken();
        int pos;
        case ($urandom_range(0, 7))
            0: begin
                build_valid();
                lit[$urandom_range(0, lit.size() - 1)] = 8'($urandom_range(0, 255));
            end
            1: begin
                build_valid();
                pos = $urandom_range(0, lit.size());
                lit.insert(pos, 8'($urandom_range(0, 255)));
            end
            2: begin
                build_valid();
                lit.insert($urandom_range(0, lit.size()), CH_MINUS);
            end
            3: begin
                build_valid();
                pos = $urandom_range(1, lit.size());
                lit.insert(pos, $urandom_range(0, 1) ? CH_LX : CH_UX);
            end
            4: begin
                if ($urandom_range(0, 1)) add_char(CH_MINUS);
                add_char(CH_0);
                add_char(CH_LX);
            end
            5: begin
                add_char(CH_0);
                add_char(CH_0 + 8'($urandom_range(0, 9)));
            end
            6: add_char(CH_MINUS);
            default: begin
                repeat ($urandom_range(1, 4)) add_char(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic random_literal();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) build_valid();
        else if (pick < 65) build_boundary();
        else build_broken();
        send_literal();
    endtask

    initial begin
        int goal;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes and corner cases with negatives at reset value
        send_text("0");
        send_text("-0");
        send_text("4294967295");
        send_text("4294967296");
        send_text("-2147483648");
        send_text("-2147483649");
        send_text("0XFFFFFFFF");
        send_text("0x1aF");
        send_text("-");
        send_text("-0x");
        send_text("0x");
        send_text("007");
        send_text("1-");
        send_text("--5");
        send_text("0x0x1");
        send_text("0x-1");
        add_char(8'hFF);
        send_literal();
        add_char(CH_SPACE);
        add_char(8'h00);
        send_literal();
        drain();

        // Directed: sign rejected while negatives are disabled
        write_allow_negative(1'b0);
        send_text("-5");
        send_text("-0x1");
        send_text("7");
        drain();

        // Random phases with varied register settings and handshake pressure
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0) write_allow_negative(1'b0);
            else if (ph == 1) write_allow_negative(1'b1);
            else write_allow_negative($urandom_range(0, 1));
            calm <= (ph == 2);
            if (ph == 4) hold_req <= hold_req + 1;
            goal = chars_sent + PHASE_CHARS;
            while (chars_sent < goal) begin
                random_literal();
                // mid-phase pause until every result is back
                if (ph == 5 && chars_sent > goal - PHASE_CHARS / 2 && board.pending() != 0)
                    drain();
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (board.pending() != 0) begin
            $display("%0t: results expected %0d actual 0", $time, board.pending());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/silp_pkg.sv
design/strict_integer_literal_parser_core.sv
verif/tb_strict_integer_literal_parser_core.sv
